FILE: hdl/cpll_pkg.sv
// shared types, widths and command codes for the calibrated piecewise-linear lookup
// used by the top level, the serial divider and the port checker
`default_nettype none

package cpll_pkg;

    localparam int CMD_W          = 2;
    localparam int ENTRY_W        = 4;
    localparam int FLOW_W         = 16;
    localparam int COUNT_W        = 16;
    localparam int S_TDATA_W      = ((ENTRY_W + FLOW_W + COUNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W      = ((COUNT_W + 7) / 8) * 8;
    localparam int POINTS_DEFAULT = 10;

    // signed spans and differences of 16-bit values
    localparam int SPAN_W    = FLOW_W + 1;
    // product of two spans, also the dividend magnitude width
    localparam int NUM_W     = 2 * SPAN_W;
    localparam int DEN_W     = FLOW_W;
    // quotient plus offset before clamping
    localparam int RES_W     = NUM_W + 2;
    // divider retires two quotient bits per cycle
    localparam int DIV_CYCLES = NUM_W / 2;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECAL  = 2'd2;

    localparam logic [FLOW_W-1:0]  FLOW_ZERO_SUB = 16'd100;
    localparam logic [COUNT_W-1:0] COUNT_MIN     = 16'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

    // which segment of the table brackets the requested flow
    typedef enum logic [1:0] {
        SEG_FIRST = 2'd0,
        SEG_MID   = 2'd1,
        SEG_PAST  = 2'd2
    } seg_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: hdl/cpll_div.sv
// unsigned shift-subtract divider, two quotient bits per cycle
// depends on cpll_pkg for widths and the request/response structs
`default_nettype none

module cpll_div
    import cpll_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_CYCLES + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   step1, step2;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, den}) begin
            t = t - {1'b0, den};
            return {1'b1, t[DEN_W-1:0]};
        end
        return {1'b0, t[DEN_W-1:0]};
    endfunction

    always_comb begin
        step1     = div_step(rem_reg, quo_reg[NUM_W-1], den_reg);
        step2     = div_step(step1[DEN_W-1:0], quo_reg[NUM_W-2], den_reg);
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_CYCLES);
            quo_next  = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-3:0], step1[DEN_W], step2[DEN_W]};
            rem_next = step2[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

`default_nettype wire

FILE: hdl/calibrated_piecewise_linear_lookup.sv
// top level: calibration table, bracket search, sequencer and output register
// depends on cpll_pkg and cpll_div
//
// usage
//   s_ channel carries one command per transfer: s_tuser is the command
//   (load, lookup, recalibrate), s_tdata packs entry, flow and value
//   m_ channel returns exactly one count per command: the clamped
//   interpolated count for lookup and recalibrate, zero for a load or an
//   unused command code
//   commands are handled one at a time; s_tready is high only while the
//   sequencer is idle
// sequence
//   load or unused command: straight to the result state, then the output register
//   lookup: the search walks the table one point per cycle up to i, the
//   bracketing point, then the shared divider works through the 34-bit
//   dividend at two bits per cycle
//   recalibrate: a lookup in which each rescaled point first makes a pass
//   through the shared multiplier and divider
// reset: sequencer goes idle, no result pending; table contents are kept
//   and are undefined until loaded
// stall: a finished count waits in the output register; the next command
//   is taken meanwhile and its result waits until the register frees
`default_nettype none

module calibrated_piecewise_linear_lookup
    import cpll_pkg::*;
#(
    parameter int POINTS = POINTS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // entry[3:0], flow[19:4], value[35:20]
    input  wire logic [CMD_W-1:0]     s_tuser,   // command[1:0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // count[15:0]
);

    localparam int IW = $clog2(POINTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(POINTS - 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_SRCH  = 11'b000_0000_0010,
        S_SMUL  = 11'b000_0000_0100,
        S_SDIV  = 11'b000_0000_1000,
        S_SWAIT = 11'b000_0001_0000,
        S_LMUL1 = 11'b000_0010_0000,
        S_LMUL2 = 11'b000_0100_0000,
        S_LSUM  = 11'b000_1000_0000,
        S_LDIV  = 11'b001_0000_0000,
        S_LWAIT = 11'b010_0000_0000,
        S_FIN   = 11'b100_0000_0000
    } state_t;

    // table storage
    logic [FLOW_W-1:0]  flow_mem  [POINTS];
    logic [COUNT_W-1:0] count_mem [POINTS];
    logic [FLOW_W-1:0]  rd_flow_reg;
    logic [COUNT_W-1:0] rd_count_reg;

    state_t                   state_reg, state_next;
    logic [CMD_W-1:0]         cmd_reg, cmd_next;
    logic [FLOW_W-1:0]        flow_reg, flow_next;      // requested flow as given
    logic [COUNT_W-1:0]       value_reg, value_next;    // measured flow
    logic [FLOW_W-1:0]        feff_reg, feff_next;      // flow with zero taken as 100
    logic [IW-1:0]            scan_reg, scan_next;      // table read address
    logic                     have_reg, have_next;      // read data is valid
    logic [IW-1:0]            idx_reg, idx_next;        // index of read data / bracket
    logic [FLOW_W-1:0]        hi_flow_reg, hi_flow_next;
    logic [COUNT_W-1:0]       hi_count_reg, hi_count_next;
    logic [FLOW_W-1:0]        lo_flow_reg, lo_flow_next;
    logic [COUNT_W-1:0]       lo_count_reg, lo_count_next;
    seg_t                     seg_reg, seg_next;
    logic                     sel_lo_reg, sel_lo_next;  // scaling the lower point
    logic                     neg_reg, neg_next;
    logic                     clamp_reg, clamp_next;
    logic signed [NUM_W-1:0]  mul_reg, mul_next;
    logic signed [NUM_W-1:0]  acc_reg, acc_next;
    logic signed [NUM_W:0]    sum_reg, sum_next;
    logic signed [RES_W-1:0]  res_reg, res_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [COUNT_W-1:0]       m_count_reg, m_count_next;

    logic                     accept;
    logic [ENTRY_W-1:0]       in_entry;
    logic [FLOW_W-1:0]        in_flow;
    logic [COUNT_W-1:0]       in_value;
    logic                     entry_ok;
    logic                     load_wr;
    logic                     count_wr;
    logic [IW-1:0]            count_wr_addr;
    logic [COUNT_W-1:0]       sat_count;
    logic                     hit;
    logic                     scale_en;

    logic signed [SPAN_W-1:0] span, den_s, cdiff, fdiff;
    logic [FLOW_W-1:0]        fbase;
    logic [SPAN_W-1:0]        den_abs;
    logic [NUM_W:0]           sum_abs;
    logic signed [SPAN_W-1:0] mul_a, mul_b;
    logic signed [NUM_W-1:0]  product;
    logic signed [NUM_W:0]    mul_ext;
    logic signed [NUM_W:0]    q_s;
    logic signed [RES_W-1:0]  res_calc;
    logic [COUNT_W-1:0]       clamp_out;

    div_req_t div_req;
    div_rsp_t div_rsp;

    cpll_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // input unpacking
    assign in_entry = s_tdata[ENTRY_W-1:0];
    assign in_flow  = s_tdata[ENTRY_W +: FLOW_W];
    assign in_value = s_tdata[ENTRY_W + FLOW_W +: COUNT_W];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign entry_ok = ({1'b0, in_entry} < (ENTRY_W + 1)'(POINTS));
    assign load_wr  = accept && (s_tuser == CMD_LOAD) && entry_ok;

    // segment arithmetic on the bracketing points
    assign span  = $signed({1'b0, hi_flow_reg}) - $signed({1'b0, lo_flow_reg});
    assign den_s = (seg_reg == SEG_FIRST) ? $signed({1'b0, hi_flow_reg}) : span;
    assign cdiff = $signed({1'b0, hi_count_reg}) - $signed({1'b0, lo_count_reg});
    assign fbase = (seg_reg == SEG_FIRST) ? '0 :
                   (seg_reg == SEG_PAST)  ? hi_flow_reg : lo_flow_reg;
    assign fdiff = $signed({1'b0, feff_reg}) - $signed({1'b0, fbase});

    assign den_abs = den_s[SPAN_W-1] ? SPAN_W'(-den_s) : SPAN_W'(den_s);
    assign sum_abs = sum_reg[NUM_W] ? (NUM_W + 1)'(-sum_reg) : (NUM_W + 1)'(sum_reg);

    // shared multiplier operand select
    always_comb begin
        mul_a = $signed({1'b0, hi_count_reg});
        mul_b = span;
        if (state_reg == S_SMUL) begin
            mul_a = $signed({1'b0, sel_lo_reg ? lo_count_reg : hi_count_reg});
            mul_b = $signed({1'b0, value_reg});
        end else if (state_reg == S_LMUL1) begin
            mul_a = (seg_reg == SEG_FIRST) ? $signed({1'b0, hi_count_reg}) : cdiff;
            mul_b = fdiff;
        end
    end
    assign product = mul_a * mul_b;

    assign mul_ext = (seg_reg == SEG_PAST) ? $signed({mul_reg[NUM_W-1], mul_reg}) : '0;

    // signed quotient plus the lower count for an inner segment
    assign q_s = neg_reg ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
    assign res_calc = $signed({{(RES_W - NUM_W - 1){q_s[NUM_W]}}, q_s})
                    + ((seg_reg == SEG_MID) ?
                       $signed({{(RES_W - COUNT_W){1'b0}}, lo_count_reg}) : '0);

    assign sat_count = (|div_rsp.quot[NUM_W-1:COUNT_W]) ? COUNT_MAX
                                                          : div_rsp.quot[COUNT_W-1:0];

    always_comb begin
        if (res_reg[RES_W-1] || (res_reg == '0)) begin
            clamp_out = COUNT_MIN;
        end else if (|res_reg[RES_W-2:COUNT_W]) begin
            clamp_out = COUNT_MAX;
        end else begin
            clamp_out = res_reg[COUNT_W-1:0];
        end
    end

    assign hit      = (feff_reg <= rd_flow_reg);
    assign scale_en = (cmd_reg == CMD_RECAL) && (flow_reg != '0);

    // divider requests
    always_comb begin
        div_req = '0;
        if (state_reg == S_SDIV) begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'(unsigned'(mul_reg));
            div_req.den   = flow_reg;
        end else if (state_reg == S_LDIV) begin
            div_req.start = 1'b1;
            div_req.num   = sum_abs[NUM_W-1:0];
            div_req.den   = den_abs[DEN_W-1:0];
        end
    end

    assign count_wr      = (state_reg == S_SWAIT) && div_rsp.done;
    assign count_wr_addr = sel_lo_reg ? (idx_reg - 1'b1) : idx_reg;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        flow_next     = flow_reg;
        value_next    = value_reg;
        feff_next     = feff_reg;
        scan_next     = scan_reg;
        have_next     = have_reg;
        idx_next      = idx_reg;
        hi_flow_next  = hi_flow_reg;
        hi_count_next = hi_count_reg;
        lo_flow_next  = lo_flow_reg;
        lo_count_next = lo_count_reg;
        seg_next      = seg_reg;
        sel_lo_next   = sel_lo_reg;
        neg_next      = neg_reg;
        clamp_next    = clamp_reg;
        mul_next      = mul_reg;
        acc_next      = acc_reg;
        sum_next      = sum_reg;
        res_next      = res_reg;
        m_count_next  = m_count_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd_next   = s_tuser;
                    flow_next  = in_flow;
                    value_next = in_value;
                    feff_next  = (in_flow == '0) ? FLOW_ZERO_SUB : in_flow;
                    scan_next  = '0;
                    have_next  = 1'b0;
                    idx_next   = '0;
                    if ((s_tuser == CMD_LOOKUP) || (s_tuser == CMD_RECAL)) begin
                        clamp_next = 1'b1;
                        state_next = S_SRCH;
                    end else begin
                        // load or unused code answers zero
                        clamp_next = 1'b0;
                        res_next   = '0;
                        state_next = S_FIN;
                    end
                end
            end
            S_SRCH: begin
                scan_next = (scan_reg == LAST_IDX) ? scan_reg : scan_reg + 1'b1;
                have_next = 1'b1;
                if (have_reg) begin
                    hi_flow_next  = rd_flow_reg;
                    hi_count_next = rd_count_reg;
                    lo_flow_next  = hi_flow_reg;
                    lo_count_next = hi_count_reg;
                    if (hit) begin
                        seg_next    = (idx_reg == '0) ? SEG_FIRST : SEG_MID;
                        // first point or exact match rescales one point only
                        sel_lo_next = !((idx_reg == '0) || (flow_reg == rd_flow_reg));
                        state_next  = scale_en ? S_SMUL : S_LMUL1;
                    end else if (idx_reg == LAST_IDX) begin
                        // beyond the table: extend the last segment
                        seg_next    = SEG_PAST;
                        sel_lo_next = 1'b1;
                        state_next  = scale_en ? S_SMUL : S_LMUL1;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_SMUL: begin
                mul_next   = product;
                state_next = S_SDIV;
            end
            S_SDIV: begin
                state_next = S_SWAIT;
            end
            S_SWAIT: begin
                if (div_rsp.done) begin
                    if (sel_lo_reg) begin
                        lo_count_next = sat_count;
                        sel_lo_next   = 1'b0;
                        state_next    = S_SMUL;
                    end else begin
                        hi_count_next = sat_count;
                        state_next    = S_LMUL1;
                    end
                end
            end
            S_LMUL1: begin
                mul_next   = product;
                state_next = S_LMUL2;
            end
            S_LMUL2: begin
                acc_next   = mul_reg;
                mul_next   = product;
                state_next = S_LSUM;
            end
            S_LSUM: begin
                if (den_s == '0) begin
                    // zero span takes the upper count
                    res_next   = $signed({{(RES_W - COUNT_W){1'b0}}, hi_count_reg});
                    state_next = S_FIN;
                end else begin
                    sum_next   = $signed({acc_reg[NUM_W-1], acc_reg}) + mul_ext;
                    state_next = S_LDIV;
                end
            end
            S_LDIV: begin
                neg_next   = sum_reg[NUM_W] ^ den_s[SPAN_W-1];
                state_next = S_LWAIT;
            end
            S_LWAIT: begin
                if (div_rsp.done) begin
                    res_next   = res_calc;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_count_next  = clamp_reg ? clamp_out : '0;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // table writes and registered reads
    always_ff @(posedge aclk) begin
        if (load_wr) begin
            flow_mem[in_entry[IW-1:0]] <= in_flow;
        end
        if (load_wr) begin
            count_mem[in_entry[IW-1:0]] <= in_value;
        end else if (count_wr) begin
            count_mem[count_wr_addr] <= sat_count;
        end
        rd_flow_reg  <= flow_mem[scan_reg];
        rd_count_reg <= count_mem[scan_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cmd_reg      <= cmd_next;
        flow_reg     <= flow_next;
        value_reg    <= value_next;
        feff_reg     <= feff_next;
        scan_reg     <= scan_next;
        have_reg     <= have_next;
        idx_reg      <= idx_next;
        hi_flow_reg  <= hi_flow_next;
        hi_count_reg <= hi_count_next;
        lo_flow_reg  <= lo_flow_next;
        lo_count_reg <= lo_count_next;
        seg_reg      <= seg_next;
        sel_lo_reg   <= sel_lo_next;
        neg_reg      <= neg_next;
        clamp_reg    <= clamp_next;
        mul_reg      <= mul_next;
        acc_reg      <= acc_next;
        sum_reg      <= sum_next;
        res_reg      <= res_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_count_reg);

endmodule

`default_nettype wire

FILE: hdl/cpll_checker.sv
// port-level checks for the calibrated piecewise-linear lookup, bound to the top level
// depends on cpll_pkg for the result width
`default_nettype none

module cpll_checker
    import cpll_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic       in_xfer, out_xfer;
    logic [1:0] pend_reg, pend_next;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    always_comb begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer) begin
            pend_next = pend_reg + 2'd1;
        end else if (!in_xfer && out_xfer) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // one command in the sequencer at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("input taken while a command is in progress");

    // every shown result belongs to a command taken earlier
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pend_reg != 2'd0))
        else $error("result without an outstanding command");

    // at most one result waiting and one command in progress
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many outstanding commands");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind calibrated_piecewise_linear_lookup cpll_checker u_cpll_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: test/tb_top.sv
// self-checking bench for calibrated_piecewise_linear_lookup: a directed command table, then
// random table loads, lookups and recalibrations scored against an in-bench count predictor
// depends on cpll_pkg and the rtl top level only
`default_nettype none

module tb_top
    import cpll_pkg::*;
();

    localparam int POINTS        = POINTS_DEFAULT;
    localparam int ITEM_TARGET   = 1950;
    localparam int DIRECTED_ROWS = 25;
    localparam int STUCK_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int PAD_W         = S_TDATA_W - ENTRY_W - FLOW_W - COUNT_W;

    // code that the block answers with a zero count and no state change
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [ENTRY_W-1:0] entry;
        logic [FLOW_W-1:0]  flow;
        logic [COUNT_W-1:0] value;
        logic               known;   // count below is typed in, not predicted
        logic [COUNT_W-1:0] count;
    } directed_row_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // entry, flow, value, zero pad
    logic [CMD_W-1:0]     s_tuser  = '0;   // command
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // count

    // predictor copy of the calibration table
    logic [FLOW_W-1:0]  cal_flow  [POINTS];
    logic [COUNT_W-1:0] cal_count [POINTS];

    logic [COUNT_W-1:0] pending_counts [$];

    bit no_idle = 1'b0;
    int sink_wait = 0;
    int stuck_cycles = 0;
    int bad_counts = 0;
    int counts_seen = 0;
    int n_loads = 0;
    int n_lookups = 0;
    int n_recals = 0;
    int n_ignored = 0;
    logic [COUNT_W-1:0] want;

    // table of points 100..1000 with counts ten times the flow, so most answers are obvious
    directed_row_t plan [DIRECTED_ROWS] = '{
        '{CMD_LOAD,   4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd0,  16'd100,  16'd1000, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd1,  16'd200,  16'd2000, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd2,  16'd300,  16'd3000, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd3,  16'd400,  16'd4000, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd4,  16'd500,  16'd5000, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd5,  16'd600,  16'd6000, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd6,  16'd700,  16'd7000, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd7,  16'd800,  16'd8000, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd8,  16'd900,  16'd9000, 1'b1, 16'd0},
        '{CMD_LOAD,   4'd9,  16'd1000, 16'd10000, 1'b1, 16'd0},
        // zero flow stands for 100
        '{CMD_LOOKUP, 4'd0,  16'd0,    16'd0,    1'b1, 16'd1000},
        // below the first point, scaled through the origin
        '{CMD_LOOKUP, 4'd0,  16'd50,   16'd0,    1'b1, 16'd500},
        '{CMD_LOOKUP, 4'd0,  16'd1000, 16'd0,    1'b1, 16'd10000},
        // far past the table, clamped at the top
        '{CMD_LOOKUP, 4'd0,  16'hFFFF, 16'd0,    1'b1, 16'hFFFF},
        '{CMD_LOOKUP, 4'd0,  16'd250,  16'd0,    1'b1, 16'd2500},
        '{CMD_SPARE,  4'd15, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0},
        // zero requested flow skips the rescale
        '{CMD_RECAL,  4'd0,  16'd0,    16'hFFFF, 1'b1, 16'd1000},
        '{CMD_RECAL,  4'd0,  16'd250,  16'd500,  1'b0, 16'd0},
        '{CMD_RECAL,  4'd0,  16'd300,  16'd150,  1'b0, 16'd0},
        '{CMD_RECAL,  4'd0,  16'd50,   16'hFFFF, 1'b0, 16'd0},
        // past the table with zero measured flow: counts drop to zero, answer clamps up
        '{CMD_RECAL,  4'd0,  16'd5000, 16'd0,    1'b0, 16'd0},
        // last two points share a flow: past-table answer is the upper count
        '{CMD_LOAD,   4'd9,  16'd900,  16'd7,    1'b1, 16'd0},
        '{CMD_LOOKUP, 4'd0,  16'd2000, 16'd0,    1'b1, 16'd7},
        '{CMD_LOAD,   4'd9,  16'd1000, 16'd10000, 1'b1, 16'd0}
    };

    calibrated_piecewise_linear_lookup #(
        .POINTS(POINTS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pause_len();
        return no_idle ? 0 : int'($urandom_range(0, 3));
    endfunction

    // first point whose flow is not below the request, POINTS when there is none
    function automatic int bracket(input longint req);
        int i;
        i = 0;
        while (i < POINTS && req > longint'(cal_flow[i]))
            i++;
        return i;
    endfunction

    function automatic logic [COUNT_W-1:0] interp_count(input longint req);
        longint f, lo_f, hi_f, lo_c, hi_c, span, r, floor_v, ceil_v;
        int i;
        floor_v = COUNT_MIN;
        ceil_v  = COUNT_MAX;
        f = req;
        if (f == 0)
            f = FLOW_ZERO_SUB;
        i = bracket(f);
        if (i >= POINTS) begin
            // extrapolate along the last segment, one truncation for the whole sum
            lo_f = cal_flow[POINTS-2];
            hi_f = cal_flow[POINTS-1];
            lo_c = cal_count[POINTS-2];
            hi_c = cal_count[POINTS-1];
            span = hi_f - lo_f;
            r = (span == 0) ? hi_c : ((f - hi_f) * (hi_c - lo_c) + hi_c * span) / span;
        end else if (i == 0) begin
            lo_f = cal_flow[0];
            hi_c = cal_count[0];
            r = (lo_f == 0) ? hi_c : hi_c * f / lo_f;
        end else begin
            lo_f = cal_flow[i-1];
            hi_f = cal_flow[i];
            lo_c = cal_count[i-1];
            hi_c = cal_count[i];
            span = hi_f - lo_f;
            r = (span == 0) ? hi_c : (hi_c - lo_c) * (f - lo_f) / span + lo_c;
        end
        if (r < floor_v)
            r = floor_v;
        if (r > ceil_v)
            r = ceil_v;
        return r[COUNT_W-1:0];
    endfunction

    function automatic void rescale_point(input int k, input longint meas, input longint req);
        longint v, c;
        if (k >= POINTS || req == 0)
            return;
        c = cal_count[k];
        v = c * meas / req;
        if (v > longint'(COUNT_MAX))
            v = COUNT_MAX;
        cal_count[k] = v[COUNT_W-1:0];
    endfunction

    // updates the predictor's table and returns the count the block must answer with
    function automatic logic [COUNT_W-1:0] expected_count(input logic [CMD_W-1:0] cmd,
            input logic [ENTRY_W-1:0] entry, input logic [FLOW_W-1:0] flow,
            input logic [COUNT_W-1:0] value);
        int i;
        longint req, meas;
        req  = flow;
        meas = value;
        case (cmd)
            CMD_LOAD: begin
                if (entry < POINTS) begin
                    cal_flow[entry]  = flow;
                    cal_count[entry] = value;
                end
                return '0;
            end
            CMD_LOOKUP: return interp_count(req);
            CMD_RECAL: begin
                if (req != 0) begin
                    i = bracket(req);
                    if (i >= POINTS) begin
                        rescale_point(POINTS - 2, meas, req);
                        rescale_point(POINTS - 1, meas, req);
                    end else if (i == 0 || req == longint'(cal_flow[i])) begin
                        rescale_point(i, meas, req);
                    end else begin
                        rescale_point(i - 1, meas, req);
                        rescale_point(i, meas, req);
                    end
                end
                return interp_count(req);
            end
            default: return '0;
        endcase
    endfunction

    // request flows aimed at the table: points, segments, both ends and beyond
    function automatic logic [FLOW_W-1:0] probe_flow();
        int k, lo, hi;
        k  = $urandom_range(0, POINTS - 2);
        lo = cal_flow[k];
        hi = cal_flow[k+1];
        if (lo > hi) begin
            lo = cal_flow[k+1];
            hi = cal_flow[k];
        end
        case ($urandom_range(0, 9))
            0: return '0;
            1: return FLOW_W'($urandom_range(0, 65535));
            2: return cal_flow[$urandom_range(0, POINTS - 1)];
            3: return FLOW_W'($urandom_range(cal_flow[0], 0));
            4: return FLOW_W'($urandom_range(65535, cal_flow[POINTS-1]));
            5: return FLOW_W'((hi < 65535) ? hi + 1 : hi);
            default: return FLOW_W'($urandom_range(hi, lo));
        endcase
    endfunction

    // measured flow mostly within a factor of two of the request
    function automatic logic [COUNT_W-1:0] probe_measured(input logic [FLOW_W-1:0] f);
        int hi;
        hi = 2 * int'(f);
        if (hi > 65535)
            hi = 65535;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COUNT_MAX;
            2: return COUNT_W'($urandom_range(0, 65535));
            default: return COUNT_W'($urandom_range(hi, int'(f) / 2));
        endcase
    endfunction

    // one command transfer; the answer is predicted at the accepting edge
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ENTRY_W-1:0] entry,
            input logic [FLOW_W-1:0] flow, input logic [COUNT_W-1:0] value,
            input logic known, input logic [COUNT_W-1:0] known_count);
        int gap;
        logic [COUNT_W-1:0] predicted;
        gap = pause_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{PAD_W{1'b0}}, value, flow, entry};
        do @(posedge aclk); while (!s_tready);
        predicted = expected_count(cmd, entry, flow, value);
        pending_counts.push_back(known ? known_count : predicted);
        if (cmd == CMD_LOAD && entry < POINTS)
            n_loads++;
        else if (cmd == CMD_LOOKUP)
            n_lookups++;
        else if (cmd == CMD_RECAL)
            n_recals++;
        else
            n_ignored++;
    endtask

    initial begin
        int pick, fl, cn;
        logic wild;
        logic [FLOW_W-1:0] f;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_cmd(plan[r].cmd, plan[r].entry, plan[r].flow, plan[r].value,
                     plan[r].known, plan[r].count);

        // ignored commands do not count toward the target
        while (n_loads + n_lookups + n_recals < ITEM_TARGET) begin
            if ($urandom_range(0, 49) == 0)
                no_idle = !no_idle;
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                // fresh ascending table, now and then with repeated flows or wild counts
                fl   = $urandom_range(0, 300);
                cn   = $urandom_range(0, 2000);
                wild = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < POINTS; k++) begin
                    send_cmd(CMD_LOAD, ENTRY_W'(k), FLOW_W'(fl),
                             wild ? COUNT_W'($urandom_range(0, 65535)) : COUNT_W'(cn),
                             1'b0, '0);
                    fl += ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 6000));
                    cn += $urandom_range(0, 6000);
                end
            end else if (pick < 10) begin
                // single overwrite, may break the ordering of the table
                send_cmd(CMD_LOAD, ENTRY_W'($urandom_range(0, POINTS - 1)),
                         FLOW_W'($urandom_range(0, 65535)), COUNT_W'($urandom_range(0, 65535)),
                         1'b0, '0);
            end else if (pick < 13) begin
                send_cmd(CMD_LOAD, ENTRY_W'($urandom_range(POINTS, 15)),
                         FLOW_W'($urandom_range(0, 65535)), COUNT_W'($urandom_range(0, 65535)),
                         1'b0, '0);
            end else if (pick < 15) begin
                send_cmd(CMD_SPARE, ENTRY_W'($urandom_range(0, 15)),
                         FLOW_W'($urandom_range(0, 65535)), COUNT_W'($urandom_range(0, 65535)),
                         1'b0, '0);
            end else if (pick < 60) begin
                send_cmd(CMD_LOOKUP, ENTRY_W'($urandom_range(0, 15)), probe_flow(),
                         COUNT_W'($urandom_range(0, 65535)), 1'b0, '0);
            end else begin
                f = probe_flow();
                send_cmd(CMD_RECAL, ENTRY_W'($urandom_range(0, 15)), f, probe_measured(f),
                         1'b0, '0);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_counts.size() != 0)
            @(posedge aclk);
        // catch any stray extra count
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d table loads, %0d lookups, %0d recalibrations, %0d ignored commands",
                 n_loads, n_lookups, n_recals, n_ignored);
        $display("%0d counts compared, %0d wrong or unexpected", counts_seen, bad_counts);
        if (bad_counts == 0 && pending_counts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // result side: score each count transfer, then hold off for a random number of cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                counts_seen++;
                if (pending_counts.size() == 0) begin
                    $error("count: no result pending, actual %0d", m_tdata[COUNT_W-1:0]);
                    bad_counts++;
                end else begin
                    want = pending_counts.pop_front();
                    if (m_tdata[COUNT_W-1:0] !== want) begin
                        $error("count: expected %0d, actual %0d", want, m_tdata[COUNT_W-1:0]);
                        bad_counts++;
                    end
                end
                sink_wait = pause_len();
            end
            if (sink_wait > 0) begin
                m_tready <= 1'b0;
                sink_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

`default_nettype wire

FILE: files.f
hdl/cpll_pkg.sv
hdl/cpll_div.sv
hdl/calibrated_piecewise_linear_lookup.sv
hdl/cpll_checker.sv
test/tb_top.sv
